// ===== rtl/core/bsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 10;

	// longest raw frame, start byte included; must stay within 2 .. 2**CNT_W-1
	localparam int unsigned MAX_FRAME = 512;

	localparam logic [BYTE_W-1:0] START_MIN = 8'hF1;
	localparam logic [BYTE_W-1:0] END_BYTE  = 8'hFF;
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hF0;
	localparam logic [BYTE_W-1:0] ESC_LIMIT = 8'h10;

	// tuser bit positions on the master side
	localparam int unsigned TUSER_FIRST = 0;
	localparam int unsigned TUSER_ERROR = 1;
	localparam int unsigned TUSER_W     = 2;

	typedef struct packed {
		logic             in_frame;
		logic             escape_pending;
		logic             error_seen;
		logic [CNT_W-1:0] raw_count;
	} rx_state_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] frame_byte;
		logic              is_first;
		logic              is_last;
		logic              frame_error;
	} rx_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsfr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one raw byte.
module bsfr_decode #(
	parameter int unsigned MAX_FRAME = bsfr_pkg::MAX_FRAME
) (
	input  wire bsfr_pkg::rx_state_t        cur,
	input  wire [bsfr_pkg::BYTE_W-1:0]      rx_byte,
	output bsfr_pkg::rx_state_t             nxt,
	output bsfr_pkg::rx_result_t            res
);

	localparam logic [bsfr_pkg::CNT_W-1:0] MAX_CNT = bsfr_pkg::CNT_W'(MAX_FRAME);
	localparam logic [bsfr_pkg::CNT_W-1:0] CNT_ONE = bsfr_pkg::CNT_W'(1);

	logic err_next;

	always_comb begin
		nxt                 = cur;
		res.valid           = 1'b0;
		res.frame_byte      = rx_byte;
		res.is_first        = 1'b0;
		res.is_last         = 1'b0;
		res.frame_error     = 1'b0;
		err_next            = cur.error_seen;

		if (!cur.in_frame) begin
			if (rx_byte == bsfr_pkg::END_BYTE) begin
				// one-byte frame: opens and closes at once
				res.valid    = 1'b1;
				res.is_first = 1'b1;
				res.is_last  = 1'b1;
			end else if (rx_byte >= bsfr_pkg::START_MIN) begin
				res.valid          = 1'b1;
				res.is_first       = 1'b1;
				nxt.in_frame       = 1'b1;
				nxt.escape_pending = 1'b0;
				nxt.error_seen     = 1'b0;
				nxt.raw_count      = CNT_ONE;
			end
		end else if (cur.raw_count >= MAX_CNT) begin
			// overlength: this byte closes the frame with an error
			res.valid       = 1'b1;
			res.is_last     = 1'b1;
			res.frame_error = 1'b1;
			nxt             = '0;
		end else begin
			nxt.raw_count = cur.raw_count + CNT_ONE;
			if (cur.escape_pending && rx_byte < bsfr_pkg::ESC_LIMIT) begin
				nxt.escape_pending = 1'b0;
				res.valid          = 1'b1;
				res.frame_byte     = bsfr_pkg::ESC_BYTE | rx_byte;
			end else if (!cur.escape_pending && rx_byte == bsfr_pkg::ESC_BYTE) begin
				nxt.escape_pending = 1'b1;
			end else begin
				// plain data, or a bad escape passed on as data
				if (cur.escape_pending) begin
					err_next = 1'b1;
				end
				nxt.escape_pending = 1'b0;
				nxt.error_seen     = err_next;
				res.valid          = 1'b1;
				if (rx_byte == bsfr_pkg::END_BYTE) begin
					res.is_last     = 1'b1;
					res.frame_error = err_next;
					nxt             = '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/byte_stuffed_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffed frame receiver.
// Slave stream: one raw byte per beat on s_axis_tdata. Master stream: one unstuffed
// frame byte per beat, m_axis_tlast on the closing byte, m_axis_tuser carries the
// start-of-frame flag and the discard flag (valid with tlast; drop the frame when set).
// Bytes outside a frame and escape bytes produce no master beat.
// An accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being taken, so the only limit is master backpressure.
// When the master side stalls, the result register holds and one more byte waits
// in the input register; s_axis_tready drops until the result is taken.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// deframer to hunting for a start byte. Frames longer than MAX_FRAME raw bytes are
// cut at the offending byte and flagged as errored.
module byte_stuffed_frame_receiver_unit #(
	parameter int unsigned MAX_FRAME = bsfr_pkg::MAX_FRAME
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire [bsfr_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] rx_byte
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [bsfr_pkg::BYTE_W-1:0]       m_axis_tdata,  // [7:0] frame_byte
	output logic                              m_axis_tlast,
	output logic [bsfr_pkg::TUSER_W-1:0]      m_axis_tuser   // [0] is_first, [1] frame_error
);

	logic                         valid_s1;
	logic [bsfr_pkg::BYTE_W-1:0]  byte_s1;
	bsfr_pkg::rx_state_t          state_q;
	bsfr_pkg::rx_state_t          state_nxt;
	bsfr_pkg::rx_result_t         res;
	logic                         out_free;
	logic                         advance;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	bsfr_decode #(
		.MAX_FRAME (MAX_FRAME)
	) u_decode (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				m_axis_tvalid <= advance && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			m_axis_tdata                          <= res.frame_byte;
			m_axis_tlast                          <= res.is_last;
			m_axis_tuser[bsfr_pkg::TUSER_FIRST]   <= res.is_first;
			m_axis_tuser[bsfr_pkg::TUSER_ERROR]   <= res.frame_error;
		end
	end

	// discard flag only ever rides on a closing beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[bsfr_pkg::TUSER_ERROR] |-> m_axis_tlast)
		else $error("frame_error set on a beat that is not last");

	// while hunting, the frame state is fully cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.in_frame |-> (!state_q.escape_pending && !state_q.error_seen &&
			state_q.raw_count == '0))
		else $error("stale frame state while hunting");

	// raw length never runs past the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.raw_count <= bsfr_pkg::CNT_W'(MAX_FRAME))
		else $error("raw_count beyond MAX_FRAME");

	// an opening byte that does not close the frame leaves the deframer inside it
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid && res.is_first && !res.is_last |=> state_q.in_frame)
		else $error("start byte did not open a frame");

endmodule

`default_nettype wire

// ===== sim/tb_byte_stuffed_frame_receiver_unit.sv =====
`timescale 1ns / 1ps

module tb_byte_stuffed_frame_receiver_unit;
	import bsfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 200;
	localparam int RANDOM_ITEMS   = 450;
	localparam int TAIL_CYCLES    = 8;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		byte_t data;
		logic  first;
		logic  last;
		logic  error;
	} frame_beat_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	byte_t               s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	byte_t               m_axis_tdata;
	logic                m_axis_tlast;
	logic [TUSER_W-1:0]  m_axis_tuser;

	byte_stuffed_frame_receiver_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// deframer state as the testbench sees it
	bit          in_frm;
	bit          esc_pend;
	bit          err_seen;
	int          raw_len;
	frame_beat_t expected_beats[$];

	int n_sent, n_beats, n_frames, n_bad_frames, n_err, idle_cycles;

	bit tx_stall_en, rx_stall_en, long_hold_req;
	int rx_stall_left;

	function automatic frame_beat_t make_beat(byte_t d, logic f, logic l, logic e);
		frame_beat_t r;
		r.data  = d;
		r.first = f;
		r.last  = l;
		r.error = e;
		return r;
	endfunction

	function void enter_hunt();
		in_frm   = 1'b0;
		esc_pend = 1'b0;
		err_seen = 1'b0;
		raw_len  = 0;
	endfunction

	function void deframe_byte(byte_t b);
		if (!in_frm) begin
			if (b == END_BYTE) begin
				expected_beats.push_back(make_beat(b, 1'b1, 1'b1, 1'b0));
			end else if (b >= START_MIN) begin
				expected_beats.push_back(make_beat(b, 1'b1, 1'b0, 1'b0));
				in_frm   = 1'b1;
				esc_pend = 1'b0;
				err_seen = 1'b0;
				raw_len  = 1;
			end
		end else if (raw_len + 1 > MAX_FRAME) begin
			// overlength: this byte closes the frame as-is
			expected_beats.push_back(make_beat(b, 1'b0, 1'b1, 1'b1));
			enter_hunt();
		end else begin
			raw_len++;
			if (esc_pend && b < ESC_LIMIT) begin
				esc_pend = 1'b0;
				expected_beats.push_back(make_beat(ESC_BYTE | b, 1'b0, 1'b0, 1'b0));
			end else if (!esc_pend && b == ESC_BYTE) begin
				esc_pend = 1'b1;
			end else begin
				if (esc_pend) begin
					esc_pend = 1'b0;
					err_seen = 1'b1;
				end
				if (b == END_BYTE) begin
					expected_beats.push_back(make_beat(b, 1'b0, 1'b1, err_seen));
					enter_hunt();
				end else begin
					expected_beats.push_back(make_beat(b, 1'b0, 1'b0, 1'b0));
				end
			end
		end
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic byte_t rand_byte(int unsigned lo, int unsigned hi);
		return byte_t'($urandom_range(lo, hi));
	endfunction

	// predict on input beats, then check output beats, plus the watchdog
	always @(posedge clk) begin : scoreboard
		frame_beat_t got, want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata);
				n_sent++;
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				got = make_beat(m_axis_tdata, m_axis_tuser[TUSER_FIRST], m_axis_tlast,
					m_axis_tuser[TUSER_ERROR]);
				n_beats++;
				if (got.last) begin
					n_frames++;
					if (got.error)
						n_bad_frames++;
				end
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat data=%02h first=%0b last=%0b error=%0b",
						$time, got.data, got.first, got.last, got.error);
					n_err++;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						$display({"%0t: beat mismatch, expected data=%02h first=%0b",
							" last=%0b error=%0b, got data=%02h first=%0b last=%0b",
							" error=%0b"},
							$time, want.data, want.first, want.last, want.error,
							got.data, got.first, got.last, got.error);
						n_err++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// downstream ready: random stalls, or one long hold on request
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			rx_stall_left = LONG_HOLD;
		end else if (rx_stall_left == 0 && rx_stall_en && $urandom_range(0, 3) == 0) begin
			rx_stall_left = gap_len();
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task send_raw(input byte_t b);
		int gap;
		gap = (tx_stall_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// frame payload byte, escaped where it has to be (and sometimes where it may be)
	task send_stuffed(input byte_t p);
		if (p >= ESC_BYTE && (p == ESC_BYTE || p == END_BYTE || $urandom_range(0, 3) == 0)) begin
			send_raw(ESC_BYTE);
			send_raw(p - ESC_BYTE);
		end else begin
			send_raw(p);
		end
	endtask

	task wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	task test_hunt_drop();
		send_raw(8'h00);
		send_raw(8'h7F);
		send_raw(8'h80);
		send_raw(ESC_BYTE);
	endtask

	task test_one_byte_frame();
		send_raw(END_BYTE);
	endtask

	task test_plain_frame();
		send_raw(8'hFE);
		send_raw(START_MIN);  // start codes inside a frame are plain data
		send_raw(8'h00);
		send_raw(END_BYTE);
	endtask

	task test_escapes();
		send_raw(START_MIN);
		send_raw(ESC_BYTE);
		send_raw(8'h00);
		send_raw(ESC_BYTE);
		send_raw(ESC_LIMIT - 8'h01);
		send_raw(END_BYTE);
	endtask

	task test_bad_escapes();
		send_raw(8'hF2);
		send_raw(ESC_BYTE);
		send_raw(ESC_LIMIT);
		send_raw(ESC_BYTE);
		send_raw(ESC_BYTE);  // bad escape; the second F0 is data, not a new escape
		send_raw(END_BYTE);
		send_raw(8'hF3);
		send_raw(ESC_BYTE);
		send_raw(END_BYTE);  // bad escape that also closes the frame
	endtask

	task test_output_stall();
		tx_stall_en   = 1'b0;
		long_hold_req = 1'b1;
		send_raw(8'hF4);
		repeat (30) send_stuffed(rand_byte(0, 255));
		send_raw(END_BYTE);
		wait_drained();
		tx_stall_en = 1'b1;
	endtask

	task test_overlength();
		// one byte too many, with an escape pending at the limit
		send_raw(8'hF5);
		repeat (MAX_FRAME - 2) send_raw(rand_byte(0, ESC_BYTE - 1));
		send_raw(ESC_BYTE);
		send_raw(rand_byte(0, 255));
		send_raw(END_BYTE);
	endtask

	task test_random_traffic();
		int    base, dropped, kind, n;
		byte_t start, bad;
		base    = n_sent;
		dropped = 0;
		while (n_sent - base - dropped < RANDOM_ITEMS) begin
			tx_stall_en = ($urandom_range(0, 4) != 0);
			rx_stall_en = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				start = ($urandom_range(0, 15) == 0) ? END_BYTE :
					rand_byte(START_MIN, 8'hFE);
				send_raw(start);
				if (start != END_BYTE) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) :
						$urandom_range(0, 12);
					repeat (n) send_stuffed(rand_byte(0, 255));
					send_raw(END_BYTE);
				end
			end else if (kind < 16) begin
				n = $urandom_range(1, 6);
				repeat (n) send_raw(rand_byte(0, START_MIN - 1));
				dropped += n;
			end else if (kind < 18) begin
				send_raw(rand_byte(START_MIN, 8'hFE));
				repeat ($urandom_range(0, 5)) send_stuffed(rand_byte(0, 255));
				send_raw(ESC_BYTE);
				bad = rand_byte(ESC_LIMIT, 255);
				send_raw(bad);
				if (bad != END_BYTE) begin
					repeat ($urandom_range(0, 5)) send_stuffed(rand_byte(0, 255));
					send_raw(END_BYTE);
				end
			end else begin
				repeat ($urandom_range(1, 16)) send_raw(rand_byte(0, 255));
			end
		end
		tx_stall_en = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	initial begin
		enter_hunt();
		tx_stall_en = 1'b1;
		rx_stall_en = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_hunt_drop();
		test_one_byte_frame();
		test_plain_frame();
		test_escapes();
		test_bad_escapes();
		wait_drained();
		test_output_stall();
		test_overlength();
		wait_drained();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d raw bytes in, %0d beats out, %0d frames (%0d flagged bad)",
			n_sent, n_beats, n_frames, n_bad_frames);
		$display("hunting, escapes, bad escapes, overlength, long output hold, random traffic");
		if (n_err == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bsfr_pkg.sv
rtl/core/bsfr_decode.sv
rtl/core/byte_stuffed_frame_receiver_unit.sv
sim/tb_byte_stuffed_frame_receiver_unit.sv
